@@ design/lnsc_pkg.sv @@
// Shared widths, codes and handshake structs for the letterbox nearest scaler.
package lnsc_pkg;

   localparam int LNSC_SRC_MAX_WIDTH  = 256;
   localparam int LNSC_SRC_MAX_HEIGHT = 256;

   localparam int SRC_W    = 9;
   localparam int DST_W    = 12;
   localparam int PIX_W    = 24;
   localparam int CSR_IDX_W = 2;
   localparam int DIVIDEND_W = DST_W + SRC_W;
   localparam int DIVISOR_W  = DST_W;

   localparam logic [CSR_IDX_W-1:0] CSR_SRC_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_WIDTH  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_HEIGHT = 2'd3;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_READ  = 1'b1;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVISOR_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic [DIVIDEND_W-1:0] quotient;
   } div_rsp_type;

endpackage

@@ design/letterbox_nearest_scaler_top.sv @@
// Letterbox nearest-neighbor scaler: sequencer, configuration and output stage.
// A write request is stored as it is accepted; a read goes straight to the response stage off
// frame, through one or two fit passes in the border, and otherwise through the fit passes, a
// column and a row pass through the shared bit-serial divider and a frame-store read.
// One request is in work at a time; the next can be taken in the cycle after a response is
// registered. Reset restores 256x256 into 640x480; the frame store is not cleared.
module letterbox_nearest_scaler_top
   import lnsc_pkg::*;
#(
   parameter int SRC_MAX_WIDTH  = LNSC_SRC_MAX_WIDTH,
   parameter int SRC_MAX_HEIGHT = LNSC_SRC_MAX_HEIGHT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [47:0]          req_tdata,  // col[11:0], row[23:12], pixel_in[47:24]
   input  logic [0:0]           req_tuser,  // command[0]
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [PIX_W-1:0]     rsp_tdata,  // pixel_out[23:0]
   output logic [0:0]           rsp_tuser,  // padded[0]
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DST_W-1:0]     csr_wdata
);

   localparam int DEPTH  = SRC_MAX_WIDTH * SRC_MAX_HEIGHT;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CLAMP_W = 13;

   typedef enum logic [2:0] {
      S_IDLE, S_FIT1, S_FIT2, S_CHECK, S_XDIV, S_YDIV, S_MEM, S_DONE
   } state_type;

   state_type          state_ff;
   logic [SRC_W-1:0]   src_width_ff, src_height_ff;
   logic [DST_W-1:0]   dst_width_ff, dst_height_ff;
   logic [DST_W-1:0]   col_ff, row_ff, nw_ff, nh_ff, x_ff, y_ff;
   logic [SRC_W-1:0]   sx_ff, sy_ff;
   logic               pad_ff, div_run_ff;
   logic               rsp_valid_ff;
   logic [PIX_W-1:0]   rsp_pix_ff;
   logic               rsp_pad_ff;

   logic [SRC_W-1:0]   sw, sh;
   logic               wide;
   logic [DST_W-1:0]   col_in, row_in;
   logic               req_fire, wr_en;
   logic [23:0]        wr_addr_w, rd_addr_w;
   div_req_type        div_req;
   div_rsp_type        div_rsp;
   logic [PIX_W-1:0]   mem_rdata;
   logic [DST_W-1:0]   xo, yo;
   logic [DST_W-1:0]   x_c, y_c;
   logic               slot_free;

   function automatic logic [SRC_W-1:0] clamp_src(logic [SRC_W-1:0] v, int maxv);
      logic [CLAMP_W-1:0] mv;
      mv = CLAMP_W'(maxv);
      if (v == '0) return SRC_W'(1);
      if ({{(CLAMP_W-SRC_W){1'b0}}, v} > mv) return mv[SRC_W-1:0];
      return v;
   endfunction

   assign sw   = clamp_src(src_width_ff, SRC_MAX_WIDTH);
   assign sh   = clamp_src(src_height_ff, SRC_MAX_HEIGHT);
   assign wide = sw > sh;

   assign col_in   = req_tdata[11:0];
   assign row_in   = req_tdata[23:12];
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire = req_tvalid && req_tready;
   assign wr_en    = req_fire && (req_tuser[0] == CMD_WRITE)
                     && (col_in < {3'b0, sw}) && (row_in < {3'b0, sh});
   assign wr_addr_w = row_in * 24'(SRC_MAX_WIDTH) + 24'(col_in);
   assign rd_addr_w = sy_ff * 24'(SRC_MAX_WIDTH) + 24'(sx_ff);

   // Divider operands follow the sequencer state.
   always_comb begin
      div_req.start    = !div_run_ff && (state_ff == S_FIT1 || state_ff == S_FIT2
                         || state_ff == S_XDIV || state_ff == S_YDIV);
      div_req.dividend = '0;
      div_req.divisor  = DIVISOR_W'(1);
      unique case (state_ff)
         S_FIT1: begin
            if (wide) begin
               div_req.dividend = DIVIDEND_W'(dst_width_ff) * DIVIDEND_W'(sh);
               div_req.divisor  = {3'b0, sw};
            end else begin
               div_req.dividend = DIVIDEND_W'(dst_height_ff) * DIVIDEND_W'(sw);
               div_req.divisor  = {3'b0, sh};
            end
         end
         S_FIT2: begin
            if (wide) begin
               div_req.dividend = DIVIDEND_W'(dst_height_ff) * DIVIDEND_W'(sw);
               div_req.divisor  = {3'b0, sh};
            end else begin
               div_req.dividend = DIVIDEND_W'(dst_width_ff) * DIVIDEND_W'(sh);
               div_req.divisor  = {3'b0, sw};
            end
         end
         S_XDIV: begin
            div_req.dividend = DIVIDEND_W'(x_ff) * DIVIDEND_W'(sw);
            div_req.divisor  = nw_ff;
         end
         S_YDIV: begin
            div_req.dividend = DIVIDEND_W'(y_ff) * DIVIDEND_W'(sh);
            div_req.divisor  = nh_ff;
         end
         default: begin
         end
      endcase
   end

   assign xo  = (dst_width_ff - nw_ff) >> 1;
   assign yo  = (dst_height_ff - nh_ff) >> 1;
   assign x_c = col_ff - xo;
   assign y_c = row_ff - yo;
   assign slot_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         div_run_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         src_width_ff  <= SRC_W'(256);
         src_height_ff <= SRC_W'(256);
         dst_width_ff  <= DST_W'(640);
         dst_height_ff <= DST_W'(480);
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_SRC_WIDTH:  src_width_ff  <= csr_wdata[SRC_W-1:0];
               CSR_SRC_HEIGHT: src_height_ff <= csr_wdata[SRC_W-1:0];
               CSR_DST_WIDTH:  dst_width_ff  <= csr_wdata;
               CSR_DST_HEIGHT: dst_height_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
         // A taken response clears the valid flag; in S_DONE the output stage loads the next response instead.
         if (rsp_valid_ff && rsp_tready && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         if (div_req.start) begin
            div_run_ff <= 1'b1;
         end else if (div_rsp.done) begin
            div_run_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire && req_tuser[0] == CMD_READ) begin
                  col_ff <= col_in;
                  row_ff <= row_in;
                  pad_ff <= 1'b1;
                  if (col_in >= dst_width_ff || row_in >= dst_height_ff) begin
                     state_ff <= S_DONE;
                  end else begin
                     state_ff <= S_FIT1;
                  end
               end
            end
            S_FIT1: begin
               if (div_rsp.done) begin
                  if (wide) begin
                     nw_ff <= dst_width_ff;
                     if (div_rsp.quotient > DIVIDEND_W'(dst_height_ff)) begin
                        nh_ff    <= dst_height_ff;
                        state_ff <= S_FIT2;
                     end else begin
                        nh_ff    <= div_rsp.quotient[DST_W-1:0];
                        state_ff <= S_CHECK;
                     end
                  end else begin
                     nh_ff <= dst_height_ff;
                     if (div_rsp.quotient > DIVIDEND_W'(dst_width_ff)) begin
                        nw_ff    <= dst_width_ff;
                        state_ff <= S_FIT2;
                     end else begin
                        nw_ff    <= div_rsp.quotient[DST_W-1:0];
                        state_ff <= S_CHECK;
                     end
                  end
               end
            end
            S_FIT2: begin
               // The refit never exceeds the other output dimension.
               if (div_rsp.done) begin
                  if (wide) begin
                     nw_ff <= div_rsp.quotient[DST_W-1:0];
                  end else begin
                     nh_ff <= div_rsp.quotient[DST_W-1:0];
                  end
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               if (nw_ff == '0 || nh_ff == '0 || col_ff < xo || row_ff < yo
                   || x_c >= nw_ff || y_c >= nh_ff) begin
                  state_ff <= S_DONE;
               end else begin
                  x_ff     <= x_c;
                  y_ff     <= y_c;
                  state_ff <= S_XDIV;
               end
            end
            S_XDIV: begin
               if (div_rsp.done) begin
                  if (div_rsp.quotient > DIVIDEND_W'(sw - 1'b1)) begin
                     sx_ff <= sw - 1'b1;
                  end else begin
                     sx_ff <= div_rsp.quotient[SRC_W-1:0];
                  end
                  state_ff <= S_YDIV;
               end
            end
            S_YDIV: begin
               if (div_rsp.done) begin
                  if (div_rsp.quotient > DIVIDEND_W'(sh - 1'b1)) begin
                     sy_ff <= sh - 1'b1;
                  end else begin
                     sy_ff <= div_rsp.quotient[SRC_W-1:0];
                  end
                  state_ff <= S_MEM;
               end
            end
            S_MEM: begin
               pad_ff   <= 1'b0;
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (slot_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_pad_ff   <= pad_ff;
                  rsp_pix_ff   <= pad_ff ? '0 : mem_rdata;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   lnsc_divider u_divider (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   lnsc_frame_mem #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_frame_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr_w[ADDR_W-1:0]),
      .wr_data (req_tdata[47:24]),
      .rd_en   (state_ff == S_MEM),
      .rd_addr (rd_addr_w[ADDR_W-1:0]),
      .rd_data (mem_rdata)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_pix_ff;
   assign rsp_tuser  = rsp_pad_ff;

endmodule

@@ design/lnsc_divider.sv @@
// Restoring divider that produces one quotient bit per cycle.
module lnsc_divider
   import lnsc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   localparam int CNT_W = $clog2(DIVIDEND_W);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  den_ff, den_in;
   logic [DIVISOR_W:0]    trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      trial   = {rem_ff, quo_ff[DIVIDEND_W-1]};
      if (req.start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = req.dividend;
         den_in  = req.divisor;
      end else if (busy_ff) begin
         // The remainder stays below the divisor, so it fits the divisor width.
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DIVISOR_W'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIVISOR_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIVIDEND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

@@ design/lnsc_frame_mem.sv @@
// Source frame store: one write port and one registered read port.
module lnsc_frame_mem
   import lnsc_pkg::*;
#(
   parameter int DEPTH  = LNSC_SRC_MAX_WIDTH * LNSC_SRC_MAX_HEIGHT,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [PIX_W-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [PIX_W-1:0]  rd_data
);

   logic [PIX_W-1:0] mem [DEPTH];
   logic [PIX_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for the letterbox nearest-neighbor scaler.
module tb_top;
   import lnsc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIMIT_CYCLES = 1_000_000;
   localparam int SMAX = LNSC_SRC_MAX_WIDTH;

   typedef struct {
      logic       cmd;
      int         col;
      int         row;
      int         pix;
      bit         fixed;   // expected result typed in
      int         exp_pix;
      bit         exp_pad;
   } request_row_type;

   typedef struct {
      logic [23:0] pix;
      logic        pad;
   } pixel_result_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [47:0]          req_tdata = '0;
   logic [0:0]           req_tuser = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [PIX_W-1:0]     rsp_tdata;
   logic [0:0]           rsp_tuser;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [DST_W-1:0]     csr_wdata = '0;

   letterbox_nearest_scaler_top dut (.*);

   // Shadow of the block's state.
   logic [23:0]      shadow_store [int];
   int unsigned      cfg_sw, cfg_sh, cfg_dw, cfg_dh;
   pixel_result_type expected_pixels [$];
   int               error_count = 0;
   int               cycle_count = 0;
   bit               rsp_idle_en = 1'b1;
   bit               req_idle_en = 1'b1;
   bit               hold_off = 1'b0;

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      $display("mismatch at cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   function automatic int unsigned clamp_src(input int unsigned v);
      if (v == 0) return 1;
      return (v > SMAX) ? SMAX : v;
   endfunction

   // Returns 1 when a result is produced; fills res.
   function automatic bit predict_pixel(input logic cmd, input int unsigned col,
                                        input int unsigned row, input logic [23:0] pix,
                                        output pixel_result_type res);
      int unsigned sw, sh, nw, nh, xo, yo, x, y, sx, sy;
      sw = clamp_src(cfg_sw);
      sh = clamp_src(cfg_sh);
      res.pix = '0;
      res.pad = 1'b1;
      if (cmd == CMD_WRITE) begin
         if (col < sw && row < sh) shadow_store[row * SMAX + col] = pix;
         return 1'b0;
      end
      if (col >= cfg_dw || row >= cfg_dh) return 1'b1;
      if (sw > sh) begin
         nw = cfg_dw;
         nh = (cfg_dw * sh) / sw;
         if (nh > cfg_dh) begin
            nh = cfg_dh;
            nw = (cfg_dh * sw) / sh;
         end
      end else begin
         nh = cfg_dh;
         nw = (cfg_dh * sw) / sh;
         if (nw > cfg_dw) begin
            nw = cfg_dw;
            nh = (cfg_dw * sh) / sw;
         end
      end
      if (nw == 0 || nh == 0) return 1'b1;
      xo = (cfg_dw - nw) / 2;
      yo = (cfg_dh - nh) / 2;
      if (col < xo || row < yo) return 1'b1;
      x = col - xo;
      y = row - yo;
      if (x >= nw || y >= nh) return 1'b1;
      sx = (x * sw) / nw;
      sy = (y * sh) / nh;
      if (sx > sw - 1) sx = sw - 1;
      if (sy > sh - 1) sy = sh - 1;
      res.pix = shadow_store.exists(sy * SMAX + sx) ? shadow_store[sy * SMAX + sx] : 24'h0;
      res.pad = 1'b0;
      return 1'b1;
   endfunction

   // Reads that would land on a never-written source pixel are replaced by
   // a read far outside the frame.
   function automatic bit reads_unwritten(input int unsigned col, input int unsigned row);
      int unsigned   sw, sh, nw, nh, xo, yo, sx, sy;
      sw = clamp_src(cfg_sw);
      sh = clamp_src(cfg_sh);
      if (col >= cfg_dw || row >= cfg_dh) return 1'b0;
      if (sw > sh) begin
         nw = cfg_dw; nh = (cfg_dw * sh) / sw;
         if (nh > cfg_dh) begin
            nh = cfg_dh; nw = (cfg_dh * sw) / sh;
         end
      end else begin
         nh = cfg_dh; nw = (cfg_dh * sw) / sh;
         if (nw > cfg_dw) begin
            nw = cfg_dw; nh = (cfg_dw * sh) / sw;
         end
      end
      if (nw == 0 || nh == 0) return 1'b0;
      xo = (cfg_dw - nw) / 2;
      yo = (cfg_dh - nh) / 2;
      if (col < xo || row < yo || col - xo >= nw || row - yo >= nh) return 1'b0;
      sx = ((col - xo) * sw) / nw;
      sy = ((row - yo) * sh) / nh;
      if (sx > sw - 1) sx = sw - 1;
      if (sy > sh - 1) sy = sh - 1;
      return !shadow_store.exists(sy * SMAX + sx);
   endfunction

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input int unsigned val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[DST_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_SRC_WIDTH:  cfg_sw = val & 9'h1FF;
         CSR_SRC_HEIGHT: cfg_sh = val & 9'h1FF;
         CSR_DST_WIDTH:  cfg_dw = val & 12'hFFF;
         default:        cfg_dh = val & 12'hFFF;
      endcase
   endtask

   task automatic set_sizes(input int unsigned sw, input int unsigned sh,
                            input int unsigned dw, input int unsigned dh);
      write_csr(CSR_SRC_WIDTH, sw);
      write_csr(CSR_SRC_HEIGHT, sh);
      write_csr(CSR_DST_WIDTH, dw);
      write_csr(CSR_DST_HEIGHT, dh);
   endtask

   // Waits for all results, then for the worst read latency, so a trailing
   // write is also finished before the sizes change.
   task automatic drain_block();
      int guard;
      guard = 0;
      req_tvalid <= 1'b0;
      while (expected_pixels.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (120) @(posedge clock);
   endtask

   task automatic send_request(input logic cmd, input int unsigned col,
                               input int unsigned row, input int unsigned pix,
                               input bit fixed, input int exp_pix, input bit exp_pad);
      pixel_result_type res;
      while (req_idle_en && $urandom_range(99) < 21) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {pix[23:0], row[11:0], col[11:0]};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (predict_pixel(cmd, col[11:0], row[11:0], pix[23:0], res)) begin
         if (fixed) begin
            res.pix = exp_pix[23:0];
            res.pad = exp_pad;
         end
         expected_pixels.push_back(res);
      end
   endtask

   task automatic send_random_request(input bit well_formed);
      logic        cmd;
      int unsigned col, row, pix, sw, sh;
      sw  = clamp_src(cfg_sw);
      sh  = clamp_src(cfg_sh);
      pix = $urandom() & 24'hFFFFFF;
      cmd = $urandom_range(1);
      if (well_formed && cmd == CMD_WRITE) begin
         col = $urandom_range(sw - 1);
         row = $urandom_range(sh - 1);
      end else if (well_formed) begin
         col = (cfg_dw > 0) ? $urandom_range(cfg_dw - 1) : 0;
         row = (cfg_dh > 0) ? $urandom_range(cfg_dh - 1) : 0;
      end else begin
         col = $urandom() & 12'hFFF;
         row = $urandom() & 12'hFFF;
      end
      if (cmd == CMD_READ && reads_unwritten(col, row)) begin
         col = 12'hFFF;
         row = 12'hFFF;
      end
      send_request(cmd, col, row, pix, 1'b0, 0, 1'b0);
   endtask

   // Result side: random idling and one long hold-off.
   always @(posedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= !hold_off && !(rsp_idle_en && $urandom_range(99) < 21);
   end

   always @(posedge clock) begin
      pixel_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_pixels.size() == 0) begin
            report_mismatch("response with no request waiting");
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_tdata !== want.pix)
               report_mismatch($sformatf("pixel_out %h, want %h", rsp_tdata, want.pix));
            if (rsp_tuser[0] !== want.pad)
               report_mismatch($sformatf("padded %b, want %b", rsp_tuser[0], want.pad));
         end
      end
   end

   task automatic long_hold_off();
      int n;
      n = 0;
      hold_off = 1'b1;
      while (n < 600) begin
         @(posedge clock);
         n++;
      end
      hold_off = 1'b0;
   endtask

   request_row_type directed [$];

   task automatic add_row(input logic cmd, input int col, input int row, input int pix,
                          input bit fixed, input int exp_pix, input bit exp_pad);
      request_row_type r;
      r.cmd = cmd; r.col = col; r.row = row; r.pix = pix;
      r.fixed = fixed; r.exp_pix = exp_pix; r.exp_pad = exp_pad;
      directed.push_back(r);
   endtask

   initial begin
      int sizes [4][4];
      cfg_sw = 256; cfg_sh = 256; cfg_dw = 640; cfg_dh = 480;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // After reset 256x256 fits 480x480 centred at column 80.
      add_row(CMD_WRITE, 0, 0, 24'hFFFFFF, 1'b0, 0, 1'b0);
      add_row(CMD_WRITE, 255, 255, 24'h000001, 1'b0, 0, 1'b0);
      add_row(CMD_WRITE, 4095, 4095, 24'h123456, 1'b0, 0, 1'b0);
      add_row(CMD_WRITE, 256, 0, 24'hABCDEF, 1'b0, 0, 1'b0);
      add_row(CMD_READ, 80, 0, 0, 1'b1, 24'hFFFFFF, 1'b0);
      add_row(CMD_READ, 559, 479, 0, 1'b1, 24'h000001, 1'b0);
      add_row(CMD_READ, 0, 0, 0, 1'b1, 0, 1'b1);
      add_row(CMD_READ, 79, 100, 0, 1'b1, 0, 1'b1);
      add_row(CMD_READ, 560, 100, 0, 1'b1, 0, 1'b1);
      add_row(CMD_READ, 640, 0, 0, 1'b1, 0, 1'b1);
      add_row(CMD_READ, 0, 480, 0, 1'b1, 0, 1'b1);
      add_row(CMD_READ, 4095, 4095, 0, 1'b1, 0, 1'b1);
      foreach (directed[i])
         send_request(directed[i].cmd, directed[i].col, directed[i].row, directed[i].pix,
                      directed[i].fixed, directed[i].exp_pix, directed[i].exp_pad);
      drain_block();

      // Zero source size counts as one; the whole frame maps to pixel (0,0).
      set_sizes(0, 0, 4095, 4095);
      send_request(CMD_WRITE, 0, 0, 24'h00FF00, 1'b0, 0, 1'b0);
      send_request(CMD_WRITE, 1, 0, 24'h0000FF, 1'b0, 0, 1'b0);
      send_request(CMD_READ, 0, 0, 0, 1'b1, 24'h00FF00, 1'b0);
      send_request(CMD_READ, 4094, 4094, 0, 1'b1, 24'h00FF00, 1'b0);
      drain_block();
      // Source size above the maximum saturates; zero output size pads all.
      set_sizes(511, 300, 0, 0);
      send_request(CMD_READ, 0, 0, 0, 1'b1, 0, 1'b1);
      drain_block();
      // Degenerate fit: wide source into a one-pixel-wide frame.
      set_sizes(256, 1, 1, 4095);
      send_request(CMD_READ, 0, 2047, 0, 1'b1, 0, 1'b1);
      drain_block();
      // Tall case where the fitted width would exceed the target.
      set_sizes(2, 4, 1, 4);
      send_request(CMD_WRITE, 0, 0, 24'h010203, 1'b0, 0, 1'b0);
      send_request(CMD_WRITE, 1, 3, 24'h040506, 1'b0, 0, 1'b0);
      send_request(CMD_READ, 0, 0, 0, 1'b0, 0, 1'b0);
      send_request(CMD_READ, 0, 3, 0, 1'b0, 0, 1'b0);
      drain_block();

      // Random phases; small sizes mostly, so the stores fill quickly.
      sizes = '{'{8, 5, 40, 40}, '{3, 9, 17, 31}, '{256, 256, 4095, 4095},
                '{1, 256, 4095, 1}};
      for (int ph = 0; ph < 4; ph++) begin
         set_sizes(sizes[ph][0], sizes[ph][1], sizes[ph][2], sizes[ph][3]);
         for (int i = 0; i < 250; i++) begin
            if (ph == 1 && i == 50) fork long_hold_off(); join_none
            req_idle_en = !(ph == 2 && i < 100);
            rsp_idle_en = req_idle_en;
            send_random_request($urandom_range(99) < 85);
         end
         drain_block();
      end

      if (error_count == 0 && expected_pixels.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
